>>> hdl/rbbr_pkg.sv
// Shared constants and types for the ring buffer burst read unit.
// No dependencies; used by the top level, the byte store and the checker.
package rbbr_pkg;

   localparam int DEPTH_DEF  = 64;   // default number of byte slots
   localparam int CFG_W      = 7;    // ring length register width
   localparam int BYTE_W     = 8;
   localparam int REQ_LEN_W  = 16;
   localparam int REQ_DATA_W = 24;   // write_byte + request_length
   localparam int STATUS_W   = 2;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,   // read of empty ring or zero length
      ST_FULL  = 2'd2    // write refused, ring full
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_BURST = 2'b10
   } state_type;

endpackage

>>> hdl/rbbr_store.sv
// Byte store of the ring: one write port, one read port with registered data.
// Depends on rbbr_pkg for the byte width.
module rbbr_store #(
   parameter int DEPTH = rbbr_pkg::DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [rbbr_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [rbbr_pkg::BYTE_W-1:0] rd_data
);

   logic [rbbr_pkg::BYTE_W-1:0] byte_store_ff [DEPTH];
   logic [rbbr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         byte_store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= byte_store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ring_buffer_burst_read_unit.sv
// Ring buffer with single-byte writes and burst reads over a stream interface.
// A write or an error read shows its one result the cycle after accept.
// A read burst enters the burst state, reads each byte into the registered store
// read data and moves it to the output register, one byte per cycle while the result
// stream is ready; the next item is taken once the last byte has entered the output register.
// Reset (synchronous): indices 0, ring empty, ring length DEPTH; store not cleared.
module ring_buffer_burst_read_unit #(
   parameter int DEPTH = rbbr_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbbr_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] write_byte, [23:8] request_length
   input  logic [0:0]                      req_tuser,  // [0] func
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbbr_pkg::BYTE_W-1:0]     rsp_tdata,  // [7:0] data_byte
   output logic                            rsp_tlast,
   output logic [rbbr_pkg::STATUS_W-1:0]   rsp_tuser,  // [1:0] status
   // ring length register
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rbbr_pkg::CFG_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = IDX_W + 1;

   rbbr_pkg::state_type          state_ff, state_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]             wr_idx_ff, wr_idx_in;
   logic                         full_ff, full_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [LEN_W-1:0]             remain_ff, remain_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         pend_ff, pend_in;
   logic                         pend_last_ff, pend_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rbbr_pkg::BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;
   rbbr_pkg::status_type         rsp_status_ff, rsp_status_in;

   logic                         slot_free, req_fire, csr_fire, issue, load;
   logic                         func;
   logic [rbbr_pkg::BYTE_W-1:0]  wbyte;
   logic [rbbr_pkg::REQ_LEN_W-1:0] rlen;
   logic [LEN_W-1:0]             count, n, rd_sum, wr_next, addr_next, cfg_len;
   logic                         mem_wr;
   logic [rbbr_pkg::BYTE_W-1:0]  mem_rd_data;

   assign func  = req_tuser[0];
   assign wbyte = req_tdata[rbbr_pkg::BYTE_W-1:0];
   assign rlen  = req_tdata[rbbr_pkg::REQ_DATA_W-1:rbbr_pkg::BYTE_W];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = (state_ff == rbbr_pkg::S_IDLE);
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = (state_ff == rbbr_pkg::S_IDLE) && slot_free && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;

   assign issue = (state_ff == rbbr_pkg::S_BURST) && (remain_ff != '0) && (!pend_ff || slot_free);
   assign load  = pend_ff && slot_free;

   assign mem_wr = req_fire && (func == rbbr_pkg::FUNC_WRITE) && !full_ff;

   // indices always stay below the ring length, so wrapping is one compare
   always_comb begin
      if (full_ff) begin
         count = len_ff;
      end else if (wr_idx_ff >= rd_idx_ff) begin
         count = {1'b0, wr_idx_ff} - {1'b0, rd_idx_ff};
      end else begin
         count = {1'b0, wr_idx_ff} + len_ff - {1'b0, rd_idx_ff};
      end
      if (rlen < rbbr_pkg::REQ_LEN_W'(count)) begin
         n = rlen[LEN_W-1:0];
      end else begin
         n = count;
      end
      rd_sum = {1'b0, rd_idx_ff} + n;
      if (rd_sum >= len_ff) begin
         rd_sum = rd_sum - len_ff;
      end
      wr_next = {1'b0, wr_idx_ff} + LEN_W'(1);
      if (wr_next == len_ff) begin
         wr_next = '0;
      end
      addr_next = {1'b0, addr_ff} + LEN_W'(1);
      if (addr_next == len_ff) begin
         addr_next = '0;
      end
      if (csr_data == '0) begin
         cfg_len = LEN_W'(1);
      end else if (csr_data > rbbr_pkg::CFG_W'(DEPTH)) begin
         cfg_len = LEN_W'(DEPTH);
      end else begin
         cfg_len = csr_data[LEN_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      full_in       = full_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         rbbr_pkg::S_IDLE: begin
            if (csr_fire) begin
               len_in    = cfg_len;
               rd_idx_in = '0;
               wr_idx_in = '0;
               full_in   = 1'b0;
            end else if (req_fire) begin
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
               if (func == rbbr_pkg::FUNC_WRITE) begin
                  rsp_valid_in = 1'b1;
                  if (full_ff) begin
                     rsp_status_in = rbbr_pkg::ST_FULL;
                  end else begin
                     rsp_status_in = rbbr_pkg::ST_OK;
                     wr_idx_in     = wr_next[IDX_W-1:0];
                     full_in       = (wr_next[IDX_W-1:0] == rd_idx_ff);
                  end
               end else if (rlen == '0 || count == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rbbr_pkg::ST_EMPTY;
               end else begin
                  state_in  = rbbr_pkg::S_BURST;
                  remain_in = n;
                  addr_in   = rd_idx_ff;
                  rd_idx_in = rd_sum[IDX_W-1:0];
                  full_in   = 1'b0;
               end
            end
         end
         rbbr_pkg::S_BURST: begin
            if (load) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = mem_rd_data;
               rsp_last_in   = pend_last_ff;
               rsp_status_in = rbbr_pkg::ST_OK;
               pend_in       = 1'b0;
               if (pend_last_ff) begin
                  state_in = rbbr_pkg::S_IDLE;
               end
            end
            if (issue) begin
               pend_in      = 1'b1;
               pend_last_in = (remain_ff == LEN_W'(1));
               remain_in    = remain_ff - LEN_W'(1);
               addr_in      = addr_next[IDX_W-1:0];
            end
         end
         default: begin
            state_in = rbbr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbbr_pkg::S_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         full_ff      <= 1'b0;
         len_ff       <= LEN_W'(DEPTH);
         remain_ff    <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         full_ff      <= full_in;
         len_ff       <= len_in;
         remain_ff    <= remain_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   rbbr_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_idx_ff),
      .wr_data (wbyte),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> hdl/rbbr_checker.sv
// Port-level checks for ring_buffer_burst_read_unit, bound to the top level.
// Depends on rbbr_pkg for status codes and field widths.
module rbbr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [0:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rbbr_pkg::BYTE_W-1:0]     rsp_tdata,
   input logic                            rsp_tlast,
   input logic [rbbr_pkg::STATUS_W-1:0]   rsp_tuser
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // error results, refused writes among them, are single, zero-data items
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rbbr_pkg::ST_OK |-> rsp_tlast && rsp_tdata == '0)
      else $error("malformed error result");

   // a write item answers in the next cycle
   a_write_resp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == rbbr_pkg::FUNC_WRITE
         |=> rsp_tvalid && rsp_tlast)
      else $error("write item not answered");

   // status is always a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == rbbr_pkg::ST_OK || rsp_tuser == rbbr_pkg::ST_EMPTY
         || rsp_tuser == rbbr_pkg::ST_FULL)
      else $error("undefined status code");

endmodule

bind ring_buffer_burst_read_unit rbbr_checker u_rbbr_checker (.*);

>>> tb/tb_ring_buffer_burst_read_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for ring_buffer_burst_read_unit: directed table, then random traffic.
// Needs rbbr_pkg and the DUT; predicts every response item with a ring model of its own.
module tb_ring_buffer_burst_read_unit;

   localparam int RING_SLOTS  = rbbr_pkg::DEPTH_DEF;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SEG_ITEMS   = 26;

   typedef struct packed {
      logic [rbbr_pkg::BYTE_W-1:0] data;
      logic                        last;
      rbbr_pkg::status_type        status;
   } rsp_item_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type                   kind;
      logic                           func;
      logic [rbbr_pkg::BYTE_W-1:0]    wbyte;
      logic [rbbr_pkg::REQ_LEN_W-1:0] rlen;
      logic [rbbr_pkg::CFG_W-1:0]     cfg_val;
      bit                             typed;     // expected response given in the row
      rsp_item_type                   rsp;
   } row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [rbbr_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rbbr_pkg::BYTE_W-1:0]     rsp_tdata;
   logic                            rsp_tlast;
   logic [rbbr_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [rbbr_pkg::CFG_W-1:0]      csr_data   = '0;

   // ring model state
   logic [rbbr_pkg::BYTE_W-1:0] ring_store [RING_SLOTS];
   logic [5:0]                  rd_pos;
   logic [5:0]                  wr_pos;
   logic                        ring_full;
   logic [rbbr_pkg::CFG_W-1:0]  ring_len_reg;

   rsp_item_type ring_out_q [$];
   row_type      dir_rows [$];
   int           err_cnt   = 0;
   int           cycle_cnt = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;

   ring_buffer_burst_read_unit #(.DEPTH(RING_SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("[ring_buffer_burst_read_unit] ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (ring_out_q.size() == 0) begin
            err_cnt++;
            $display("%0t: unexpected item: data %02h last %0b status %0d",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = ring_out_q.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                rsp_tuser !== want.status) begin
               err_cnt++;
               $display("%0t: expected %02h last %0b status %0d, got %02h last %0b status %0d",
                        $time, want.data, want.last, want.status,
                        rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // 0 acts as 1, anything above the store size as the store size
   function automatic int unsigned active_len();
      if (ring_len_reg == 0) return 1;
      if (ring_len_reg > RING_SLOTS) return RING_SLOTS;
      return ring_len_reg;
   endfunction

   function automatic rsp_item_type mk_rsp(logic [rbbr_pkg::BYTE_W-1:0] d, logic l,
                                           rbbr_pkg::status_type s);
      rsp_item_type x;
      x.data = d;
      x.last = l;
      x.status = s;
      return x;
   endfunction

   task automatic apply_to_ring(input logic func, input logic [rbbr_pkg::BYTE_W-1:0] wbyte,
                                input logic [rbbr_pkg::REQ_LEN_W-1:0] rlen);
      int unsigned len, r, w, cnt, n;
      len = active_len();
      r = rd_pos % len;
      w = wr_pos % len;
      if (func == rbbr_pkg::FUNC_WRITE) begin
         if (ring_full) begin
            ring_out_q.push_back(mk_rsp('0, 1'b1, rbbr_pkg::ST_FULL));
         end else begin
            ring_store[w] = wbyte;
            w = (w + 1) % len;
            wr_pos = w[5:0];
            if (w == r) ring_full = 1'b1;
            ring_out_q.push_back(mk_rsp('0, 1'b1, rbbr_pkg::ST_OK));
         end
      end else begin
         cnt = ring_full ? len : (w + len - r) % len;
         if (rlen == 0 || cnt == 0) begin
            ring_out_q.push_back(mk_rsp('0, 1'b1, rbbr_pkg::ST_EMPTY));
         end else begin
            n = (rlen < cnt) ? rlen : cnt;
            for (int unsigned k = 0; k < n; k++)
               ring_out_q.push_back(mk_rsp(ring_store[(r + k) % len], k + 1 == n,
                                           rbbr_pkg::ST_OK));
            rd_pos = 6'((r + n) % len);
            ring_full = 1'b0;
         end
      end
   endtask

   task automatic send_item(input row_type row);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row.rlen, row.wbyte};
      req_tuser  <= row.func;
      do @(posedge clock); while (!req_tready);
      apply_to_ring(row.func, row.wbyte, row.rlen);
      if (row.typed) begin
         void'(ring_out_q.pop_back());
         ring_out_q.push_back(row.rsp);
      end
   endtask

   // register writes only with nothing in flight
   task automatic write_ring_length(input logic [rbbr_pkg::CFG_W-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ring_out_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      ring_len_reg = val;
      rd_pos = '0;
      wr_pos = '0;
      ring_full = 1'b0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_row(input row_type row);
      if (row.kind == ROW_CFG) write_ring_length(row.cfg_val);
      else send_item(row);
   endtask

   function automatic row_type item_row(logic f, logic [rbbr_pkg::BYTE_W-1:0] b,
                                        logic [rbbr_pkg::REQ_LEN_W-1:0] n);
      row_type x;
      x.kind = ROW_ITEM;
      x.func = f;
      x.wbyte = b;
      x.rlen = n;
      x.cfg_val = '0;
      x.typed = 1'b0;
      x.rsp = '0;
      return x;
   endfunction

   function automatic row_type typed_row(logic f, logic [rbbr_pkg::BYTE_W-1:0] b,
                                         logic [rbbr_pkg::REQ_LEN_W-1:0] n,
                                         rbbr_pkg::status_type s);
      row_type x;
      x = item_row(f, b, n);
      x.typed = 1'b1;
      x.rsp = mk_rsp('0, 1'b1, s);
      return x;
   endfunction

   function automatic row_type cfg_row(logic [rbbr_pkg::CFG_W-1:0] v);
      row_type x;
      x = item_row(rbbr_pkg::FUNC_READ, '0, '0);
      x.kind = ROW_CFG;
      x.cfg_val = v;
      return x;
   endfunction

   // mostly writes and short reads so small rings fill, wrap and drain
   function automatic row_type random_row();
      row_type x;
      int unsigned pick;
      x = item_row(rbbr_pkg::FUNC_WRITE, 8'($urandom), 16'($urandom));
      if ($urandom_range(0, 99) >= 55) begin
         x.func = rbbr_pkg::FUNC_READ;
         pick = $urandom_range(0, 9);
         case (pick)
            0: x.rlen = '0;
            1: x.rlen = '1;
            2: x.rlen = 16'($urandom);
            default: x.rlen = 16'($urandom_range(1, active_len() + 2));
         endcase
      end
      return x;
   endfunction

   initial begin
      logic [rbbr_pkg::CFG_W-1:0] seg_cfg [4];
      int seg;
      seg_cfg = '{7'd1, 7'd2, 7'd64, 7'd127};
      ring_len_reg = 7'(RING_SLOTS);
      rd_pos = '0;
      wr_pos = '0;
      ring_full = 1'b0;
      for (int i = 0; i < RING_SLOTS; i++) ring_store[i] = '0;

      // reset length, then 0 (acts as 1), 127 (acts as full size), then 3 for wrap
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd5, rbbr_pkg::ST_EMPTY));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'hFF, 16'h0000, rbbr_pkg::ST_OK));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_READ, 8'hFF, 16'd0, rbbr_pkg::ST_EMPTY));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h00, 16'hFFFF, rbbr_pkg::ST_OK));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_READ, 8'h00, 16'hFFFF));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd1, rbbr_pkg::ST_EMPTY));
      dir_rows.push_back(cfg_row(7'd0));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'hA5, 16'd0, rbbr_pkg::ST_OK));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h5A, 16'd0, rbbr_pkg::ST_FULL));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd1));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd1, rbbr_pkg::ST_EMPTY));
      dir_rows.push_back(cfg_row(7'd127));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h3C, 16'd0, rbbr_pkg::ST_OK));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd7));
      dir_rows.push_back(cfg_row(7'd3));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h01, 16'd0, rbbr_pkg::ST_OK));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h02, 16'd0, rbbr_pkg::ST_OK));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h03, 16'd0, rbbr_pkg::ST_OK));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_WRITE, 8'h04, 16'd0, rbbr_pkg::ST_FULL));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_READ, 8'h00, 16'd2));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_WRITE, 8'h05, 16'd0));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_WRITE, 8'h06, 16'd0));
      dir_rows.push_back(item_row(rbbr_pkg::FUNC_READ, 8'h00, 16'hFFFF));
      dir_rows.push_back(typed_row(rbbr_pkg::FUNC_READ, 8'h00, 16'h8001, rbbr_pkg::ST_EMPTY));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 8;
      rx_idle_pct = 65;
      foreach (dir_rows[i]) run_row(dir_rows[i]);

      // three idling phases, three ring lengths each
      for (seg = 0; seg < 9; seg++) begin
         if (seg == 3) begin
            tx_idle_pct = 65;
            rx_idle_pct = 8;
         end else if (seg == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_ring_length(seg < 4 ? seg_cfg[seg] : 7'($urandom_range(1, 8)));
         for (int i = 0; i < SEG_ITEMS; i++) send_item(random_row());
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ring_out_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_cnt == 0)
         $display("[ring_buffer_burst_read_unit] OK");
      else
         $display("[ring_buffer_burst_read_unit] ERROR");
      $finish;
   end

endmodule
